// File: rtl/hto_pkg.sv
package hto_pkg;

   localparam int CMD_W       = 2;
   localparam int HASH_W      = 32;
   localparam int KEY_IN_W    = 64;
   localparam int VALUE_IN_W  = 32;
   localparam int SLOT_W      = 11;
   localparam int STATUS_W    = 3;
   localparam int MAIN_USED_W = 11;
   localparam int OVF_USED_W  = 9;

   // The hash is reduced modulo the main area size MOD_BITS bits per cycle.
   localparam int MOD_BITS  = 4;
   localparam int MOD_STEPS = HASH_W / MOD_BITS;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_PRESENT   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_REMOVED   = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd5;
   localparam logic [STATUS_W-1:0] STATUS_INVALID   = 3'd6;

   typedef struct packed {
      logic [CMD_W-1:0]      cmd;
      logic [HASH_W-1:0]     hash;
      logic [KEY_IN_W-1:0]   key;
      logic [VALUE_IN_W-1:0] value;
      logic [SLOT_W-1:0]     slot;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [SLOT_W-1:0]      result_slot;
      logic [VALUE_IN_W-1:0]  result_value;
      logic [MAIN_USED_W-1:0] main_used;
      logic [OVF_USED_W-1:0]  overflow_used;
   } rsp_item_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_MOD, S_RDH, S_CHAIN, S_SCAN, S_LINK,
      S_RM, S_RMW, S_RMPV, S_RMFIX, S_RMO1, S_RMO2, S_RESP
   } ctrl_state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_CLEAR, OP_LOAD, OP_MOD_STEP, OP_RD_HEAD, OP_RD_SLOT, OP_RD_NEXT,
      OP_SCAN_START, OP_SCAN_NEXT, OP_INS_MAIN, OP_INS_OVF, OP_LINK_TAIL, OP_HIT,
      OP_MISS, OP_FULL, OP_INVALID, OP_RM_MAIN_SOLO, OP_RM_HEAD_WALK, OP_RM_LAST,
      OP_RM_PV_CUT, OP_RM_HEAD_FIX, OP_RM_OVF, OP_RM_OVF_PV, OP_RM_OVF_NX, OP_EMIT
   } dp_op_type;

   typedef struct packed {
      logic             clr_done;
      logic             mod_done;
      logic [CMD_W-1:0] cmd;
      logic             slot_oor;
      logic             slot_main;
      logic             rd_valid;
      logic             key_eq;
      logic             link;
      logic             ovf_full;
      logic             pv_is_s;
      logic             sav_link;
      logic             out_free;
   } dp_stat_type;

endpackage

// File: rtl/hto_req_if.sv
interface hto_req_if;
   import hto_pkg::*;
   logic         valid;
   logic         ready;
   req_item_type item;
   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

// File: rtl/hto_rsp_if.sv
interface hto_rsp_if;
   import hto_pkg::*;
   logic         valid;
   logic         ready;
   rsp_item_type item;
   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

// File: rtl/hash_table_overflow_chaining.sv
// Hash table with a main area of MAIN_ENTRIES slots, addressed by the hash reduced
// modulo MAIN_ENTRIES, and an overflow area of OVERFLOW_ENTRIES slots numbered after
// it. Colliding keys hang off their main slot as a doubly linked chain in the
// overflow area; a free overflow slot is found by a wrapping scan from a free
// pointer that advances past each slot it hands out. Commands are insert (answers
// present with the stored value if the key exists, full if no overflow slot is
// left), lookup, and remove by slot number; removing a main slot that heads a chain
// pulls the chain's last entry into it. Each item produces exactly one result,
// which carries the occupancy of both areas after the command. All slots live in a
// single memory with one write and one registered read port. After reset the block
// clears every slot of the memory before it takes the first item. An insert or
// lookup first reduces the hash, four bits a cycle, then reads the main slot and
// each chain entry it visits; an insert into the overflow area then scans past the
// occupied slots, writes the new entry and links it to the chain's tail. A remove
// of an out-of-range slot, like an unknown command, answers invalid; a remove of
// an empty slot answers not found, and a main slot without a chain is cleared; a
// remove of an overflow slot relinks its predecessor and, when it has a successor,
// that successor too; removing a chain head walks the chain to its last entry,
// cuts that entry off its predecessor and copies its key and value into the head.
// The result sits in an output register, so the next item is taken as soon as
// that register is loaded.
module hash_table_overflow_chaining #(
   parameter int MAIN_ENTRIES     = 1024,
   parameter int OVERFLOW_ENTRIES = 256,
   parameter int KEY_WIDTH        = 64,
   parameter int VALUE_WIDTH      = 32
) (
   input logic       clock,
   input logic       reset,
   hto_req_if.sink   req_chan,
   hto_rsp_if.source rsp_chan
);
   import hto_pkg::*;

   dp_op_type   op;
   dp_stat_type stat;
   logic        req_ready;

   // The controller sequences every command; the datapath holds the memory,
   // the working registers and the result register.
   hto_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .stat      (stat),
      .req_ready (req_ready),
      .op        (op)
   );

   hto_dpath #(
      .MAIN_ENTRIES     (MAIN_ENTRIES),
      .OVERFLOW_ENTRIES (OVERFLOW_ENTRIES),
      .KEY_WIDTH        (KEY_WIDTH),
      .VALUE_WIDTH      (VALUE_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .req_item  (req_chan.item),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_item  (rsp_chan.item),
      .stat      (stat)
   );

   assign req_chan.ready = req_ready;

endmodule

// File: rtl/hto_ctrl.sv
module hto_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  hto_pkg::dp_stat_type stat,
   output logic                req_ready,
   output hto_pkg::dp_op_type  op
);
   import hto_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (stat.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (stat.cmd inside {CMD_INSERT, CMD_LOOKUP}) begin
               state_in = S_MOD;
            end else if (stat.cmd == CMD_REMOVE && !stat.slot_oor) begin
               state_in = S_RM;
            end else begin
               state_in = S_RESP;
            end
         end
         S_MOD: begin
            if (stat.mod_done) state_in = S_RDH;
         end
         S_RDH: state_in = S_CHAIN;
         S_CHAIN: begin
            if (!stat.rd_valid || stat.key_eq) begin
               state_in = S_RESP;
            end else if (stat.link) begin
               state_in = S_CHAIN;
            end else if (stat.cmd == CMD_INSERT && !stat.ovf_full) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SCAN: begin
            if (!stat.rd_valid) state_in = S_LINK;
         end
         S_LINK: state_in = S_RESP;
         S_RM: begin
            if (stat.rd_valid && stat.slot_main && stat.link) begin
               state_in = S_RMW;
            end else if (stat.rd_valid && !stat.slot_main) begin
               state_in = S_RMO1;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RMW: begin
            if (!stat.link) state_in = stat.pv_is_s ? S_RMFIX : S_RMPV;
         end
         S_RMPV: state_in = S_RMFIX;
         S_RMFIX: state_in = S_RESP;
         S_RMO1: state_in = stat.sav_link ? S_RMO2 : S_RESP;
         S_RMO2: state_in = S_RESP;
         S_RESP: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      op        = OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: op = OP_CLEAR;
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) op = OP_LOAD;
         end
         S_DECODE: begin
            if (stat.cmd inside {CMD_INSERT, CMD_LOOKUP}) begin
               op = OP_NONE;
            end else if (stat.cmd == CMD_REMOVE && !stat.slot_oor) begin
               op = OP_RD_SLOT;
            end else begin
               op = OP_INVALID;
            end
         end
         S_MOD: op = OP_MOD_STEP;
         S_RDH: op = OP_RD_HEAD;
         S_CHAIN: begin
            if (!stat.rd_valid) begin
               op = (stat.cmd == CMD_INSERT) ? OP_INS_MAIN : OP_MISS;
            end else if (stat.key_eq) begin
               op = OP_HIT;
            end else if (stat.link) begin
               op = OP_RD_NEXT;
            end else if (stat.cmd == CMD_INSERT) begin
               op = stat.ovf_full ? OP_FULL : OP_SCAN_START;
            end else begin
               op = OP_MISS;
            end
         end
         S_SCAN: op = stat.rd_valid ? OP_SCAN_NEXT : OP_INS_OVF;
         S_LINK: op = OP_LINK_TAIL;
         S_RM: begin
            if (!stat.rd_valid) begin
               op = OP_MISS;
            end else if (stat.slot_main) begin
               op = stat.link ? OP_RM_HEAD_WALK : OP_RM_MAIN_SOLO;
            end else begin
               op = OP_RM_OVF;
            end
         end
         S_RMW: op = stat.link ? OP_RD_NEXT : OP_RM_LAST;
         S_RMPV: op = OP_RM_PV_CUT;
         S_RMFIX: op = OP_RM_HEAD_FIX;
         S_RMO1: op = OP_RM_OVF_PV;
         S_RMO2: op = OP_RM_OVF_NX;
         S_RESP: begin
            if (stat.out_free) op = OP_EMIT;
         end
         default: op = OP_NONE;
      endcase
   end

endmodule

// File: rtl/hto_dpath.sv
module hto_dpath #(
   parameter int MAIN_ENTRIES     = 1024,
   parameter int OVERFLOW_ENTRIES = 256,
   parameter int KEY_WIDTH        = 64,
   parameter int VALUE_WIDTH      = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  hto_pkg::dp_op_type    op,
   input  hto_pkg::req_item_type req_item,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output hto_pkg::rsp_item_type rsp_item,
   output hto_pkg::dp_stat_type  stat
);
   import hto_pkg::*;

   localparam int TOTAL = MAIN_ENTRIES + OVERFLOW_ENTRIES;
   localparam int SW    = $clog2(TOTAL);
   localparam int XW    = (SW > SLOT_W) ? SW : SLOT_W;
   localparam int RW    = $clog2(MAIN_ENTRIES) + 1;
   localparam int MCW   = $clog2(MAIN_ENTRIES + 1);
   localparam int OCW   = $clog2(OVERFLOW_ENTRIES + 1);
   localparam int KW    = KEY_WIDTH;
   localparam int VW    = VALUE_WIDTH;
   localparam int VIW   = (VW < VALUE_IN_W) ? VW : VALUE_IN_W;
   localparam int STW   = $clog2(MOD_STEPS);

   typedef struct packed {
      logic          valid;
      logic          has_next;
      logic [SW-1:0] next;
      logic [SW-1:0] prev;
      logic [KW-1:0] key;
      logic [VW-1:0] value;
   } rec_type;

   rec_type mem_ram [0:TOTAL-1];
   rec_type mem_q;

   logic          wr_en, rd_en;
   logic [SW-1:0] wr_addr, rd_addr;
   rec_type       wr_rec;

   logic [SW-1:0]         clr_ff, clr_in;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [HASH_W-1:0]     hash_ff, hash_in;
   logic [KW-1:0]         key_ff, key_in;
   logic [VW-1:0]         val_ff, val_in;
   logic [XW-1:0]         slot_ff, slot_in;
   logic [RW-1:0]         rem_ff, rem_in;
   logic [STW-1:0]        step_ff, step_in;
   logic [SW-1:0]         cur_ff, cur_in;
   logic [SW-1:0]         tail_ff, tail_in;
   logic [SW-1:0]         p_ff, p_in;
   logic [SW-1:0]         pv_ff, pv_in;
   rec_type               sav_ff, sav_in;
   logic [SW-1:0]         fsp_ff, fsp_in;
   logic [MCW-1:0]        mcnt_ff, mcnt_in;
   logic [OCW-1:0]        ocnt_ff, ocnt_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [SW-1:0]         res_slot_ff, res_slot_in;
   logic [VW-1:0]         res_val_ff, res_val_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_item_type          rsp_item_ff, rsp_item_in;

   logic [RW-1:0]               rem_step;
   logic [SW-1:0]               h_idx, s_idx, p_nxt;
   logic                        mem_link, out_free;
   rec_type                     new_rec, mod_rec;
   logic [SW+SLOT_W-1:0]        slot_wide;
   logic [VW+VALUE_IN_W-1:0]    val_wide;
   logic [MCW+MAIN_USED_W-1:0]  mcnt_wide;
   logic [OCW+OVF_USED_W-1:0]   ocnt_wide;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ram[wr_addr] <= wr_rec;
   end

   always_ff @(posedge clock) begin
      if (rd_en) mem_q <= mem_ram[rd_addr];
   end

   assign h_idx    = SW'(rem_ff[RW-2:0]);
   assign s_idx    = slot_ff[SW-1:0];
   assign p_nxt    = (p_ff == SW'(TOTAL - 1)) ? SW'(MAIN_ENTRIES) : p_ff + 1'b1;
   assign mem_link = mem_q.has_next && ({1'b0, mem_q.next} < (SW + 1)'(TOTAL));
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Restoring reduction of the hash, MOD_BITS hash bits per cycle.
   always_comb begin
      rem_step = rem_ff;
      for (int i = 0; i < MOD_BITS; i++) begin
         rem_step = {rem_step[RW-2:0], hash_ff[HASH_W-1-i]};
         if (rem_step >= RW'(MAIN_ENTRIES)) rem_step = rem_step - RW'(MAIN_ENTRIES);
      end
   end

   always_comb begin
      new_rec          = '0;
      new_rec.valid    = 1'b1;
      new_rec.key      = key_ff;
      new_rec.value    = val_ff;
   end

   always_comb begin
      clr_in        = clr_ff;
      cmd_in        = cmd_ff;
      hash_in       = hash_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      slot_in       = slot_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      cur_in        = cur_ff;
      tail_in       = tail_ff;
      p_in          = p_ff;
      pv_in         = pv_ff;
      sav_in        = sav_ff;
      fsp_in        = fsp_ff;
      mcnt_in       = mcnt_ff;
      ocnt_in       = ocnt_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_val_in    = res_val_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_item_in   = rsp_item_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_rec        = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      mod_rec       = mem_q;
      slot_wide     = '0;
      val_wide      = '0;
      mcnt_wide     = '0;
      ocnt_wide     = '0;
      case (op)
         OP_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
         end
         OP_LOAD: begin
            cmd_in  = req_item.cmd;
            hash_in = req_item.hash;
            key_in  = req_item.key[KW-1:0];
            val_in  = VW'(req_item.value[VIW-1:0]);
            slot_in = XW'(req_item.slot);
            rem_in  = '0;
            step_in = '0;
         end
         OP_MOD_STEP: begin
            rem_in  = rem_step;
            hash_in = hash_ff << MOD_BITS;
            step_in = step_ff + 1'b1;
         end
         OP_RD_HEAD: begin
            rd_en   = 1'b1;
            rd_addr = h_idx;
            cur_in  = h_idx;
         end
         OP_RD_SLOT: begin
            rd_en   = 1'b1;
            rd_addr = s_idx;
         end
         OP_RD_NEXT: begin
            rd_en   = 1'b1;
            rd_addr = mem_q.next;
            cur_in  = mem_q.next;
         end
         OP_SCAN_START: begin
            tail_in = cur_ff;
            sav_in  = mem_q;
            p_in    = fsp_ff;
            rd_en   = 1'b1;
            rd_addr = fsp_ff;
         end
         OP_SCAN_NEXT: begin
            p_in    = p_nxt;
            rd_en   = 1'b1;
            rd_addr = p_nxt;
         end
         OP_INS_MAIN: begin
            wr_en         = 1'b1;
            wr_addr       = h_idx;
            wr_rec        = new_rec;
            mcnt_in       = mcnt_ff + 1'b1;
            res_status_in = STATUS_INSERTED;
            res_slot_in   = h_idx;
            res_val_in    = val_ff;
         end
         OP_INS_OVF: begin
            wr_en         = 1'b1;
            wr_addr       = p_ff;
            wr_rec        = new_rec;
            wr_rec.prev   = tail_ff;
            fsp_in        = p_nxt;
            ocnt_in       = ocnt_ff + 1'b1;
            res_status_in = STATUS_INSERTED;
            res_slot_in   = p_ff;
            res_val_in    = val_ff;
         end
         OP_LINK_TAIL: begin
            wr_en           = 1'b1;
            wr_addr         = tail_ff;
            wr_rec          = sav_ff;
            wr_rec.next     = p_ff;
            wr_rec.has_next = 1'b1;
         end
         OP_HIT: begin
            res_status_in = (cmd_ff == CMD_INSERT) ? STATUS_PRESENT : STATUS_FOUND;
            res_slot_in   = cur_ff;
            res_val_in    = mem_q.value;
         end
         OP_MISS: begin
            res_status_in = STATUS_NOT_FOUND;
            res_slot_in   = '0;
            res_val_in    = '0;
         end
         OP_FULL: begin
            res_status_in = STATUS_FULL;
            res_slot_in   = '0;
            res_val_in    = '0;
         end
         OP_INVALID: begin
            res_status_in = STATUS_INVALID;
            res_slot_in   = '0;
            res_val_in    = '0;
         end
         OP_RM_MAIN_SOLO: begin
            wr_en         = 1'b1;
            wr_addr       = s_idx;
            if (mcnt_ff != '0) mcnt_in = mcnt_ff - 1'b1;
            res_status_in = STATUS_REMOVED;
            res_slot_in   = s_idx;
            res_val_in    = '0;
         end
         OP_RM_HEAD_WALK: begin
            sav_in  = mem_q;
            cur_in  = mem_q.next;
            rd_en   = 1'b1;
            rd_addr = mem_q.next;
         end
         OP_RM_LAST: begin
            wr_en   = 1'b1;
            wr_addr = cur_ff;
            key_in  = mem_q.key;
            val_in  = mem_q.value;
            pv_in   = mem_q.prev;
            rd_en   = 1'b1;
            rd_addr = mem_q.prev;
            if (ocnt_ff != '0) ocnt_in = ocnt_ff - 1'b1;
         end
         OP_RM_PV_CUT: begin
            mod_rec.has_next = 1'b0;
            mod_rec.next     = '0;
            wr_en            = 1'b1;
            wr_addr          = pv_ff;
            wr_rec           = mod_rec;
         end
         OP_RM_HEAD_FIX: begin
            wr_en        = 1'b1;
            wr_addr      = s_idx;
            wr_rec       = sav_ff;
            wr_rec.key   = key_ff;
            wr_rec.value = val_ff;
            if (pv_ff == s_idx) begin
               wr_rec.has_next = 1'b0;
               wr_rec.next     = '0;
            end
            res_status_in = STATUS_REMOVED;
            res_slot_in   = s_idx;
            res_val_in    = '0;
         end
         OP_RM_OVF: begin
            sav_in  = mem_q;
            wr_en   = 1'b1;
            wr_addr = s_idx;
            pv_in   = mem_q.prev;
            rd_en   = 1'b1;
            rd_addr = mem_q.prev;
            if (ocnt_ff != '0) ocnt_in = ocnt_ff - 1'b1;
         end
         OP_RM_OVF_PV: begin
            mod_rec.has_next = sav_ff.has_next;
            mod_rec.next     = sav_ff.next;
            wr_en            = 1'b1;
            wr_addr          = pv_ff;
            wr_rec           = mod_rec;
            rd_en            = 1'b1;
            rd_addr          = sav_ff.next;
            res_status_in    = STATUS_REMOVED;
            res_slot_in      = s_idx;
            res_val_in       = '0;
         end
         OP_RM_OVF_NX: begin
            mod_rec.prev = pv_ff;
            wr_en        = 1'b1;
            wr_addr      = sav_ff.next;
            wr_rec       = mod_rec;
         end
         OP_EMIT: begin
            slot_wide                 = {{SLOT_W{1'b0}}, res_slot_ff};
            val_wide                  = {{VALUE_IN_W{1'b0}}, res_val_ff};
            mcnt_wide                 = {{MAIN_USED_W{1'b0}}, mcnt_ff};
            ocnt_wide                 = {{OVF_USED_W{1'b0}}, ocnt_ff};
            rsp_valid_in              = 1'b1;
            rsp_item_in.status        = res_status_ff;
            rsp_item_in.result_slot   = slot_wide[SLOT_W-1:0];
            rsp_item_in.result_value  = val_wide[VALUE_IN_W-1:0];
            rsp_item_in.main_used     = mcnt_wide[MAIN_USED_W-1:0];
            rsp_item_in.overflow_used = ocnt_wide[OVF_USED_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         fsp_ff       <= SW'(MAIN_ENTRIES);
         mcnt_ff      <= '0;
         ocnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         fsp_ff       <= fsp_in;
         mcnt_ff      <= mcnt_in;
         ocnt_ff      <= ocnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      hash_ff       <= hash_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      slot_ff       <= slot_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      cur_ff        <= cur_in;
      tail_ff       <= tail_in;
      p_ff          <= p_in;
      pv_ff         <= pv_in;
      sav_ff        <= sav_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_val_ff    <= res_val_in;
      rsp_item_ff   <= rsp_item_in;
   end

   always_comb begin
      stat.clr_done  = (clr_ff == SW'(TOTAL - 1));
      stat.mod_done  = (step_ff == STW'(MOD_STEPS - 1));
      stat.cmd       = cmd_ff;
      stat.slot_oor  = ({1'b0, slot_ff} >= (XW + 1)'(TOTAL));
      stat.slot_main = (slot_ff < XW'(MAIN_ENTRIES));
      stat.rd_valid  = mem_q.valid;
      stat.key_eq    = (mem_q.key == key_ff);
      stat.link      = mem_link;
      stat.ovf_full  = (ocnt_ff >= OCW'(OVERFLOW_ENTRIES));
      stat.pv_is_s   = (mem_q.prev == s_idx);
      stat.sav_link  = sav_ff.has_next && ({1'b0, sav_ff.next} < (SW + 1)'(TOTAL));
      stat.out_free  = out_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// File: rtl/hto_checker.sv
module hto_checker #(
   parameter int OVERFLOW_ENTRIES = 256
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input hto_pkg::rsp_item_type rsp_item
);
   import hto_pkg::*;

   // A result that is not taken stays offered unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("result changed while stalled");

   a_miss_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.status == STATUS_NOT_FOUND || rsp_item.status == STATUS_FULL ||
                    rsp_item.status == STATUS_INVALID)
      |-> rsp_item.result_slot == '0 && rsp_item.result_value == '0)
      else $error("failed command carries a slot or value");

   a_removed_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status == STATUS_REMOVED |-> rsp_item.result_value == '0)
      else $error("remove returned a value");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status == STATUS_FULL
      |-> rsp_item.overflow_used == OVF_USED_W'(OVERFLOW_ENTRIES))
      else $error("full reported with free overflow slots");

endmodule

bind hash_table_overflow_chaining hto_checker #(
   .OVERFLOW_ENTRIES (OVERFLOW_ENTRIES)
) u_hto_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_item  (rsp_chan.item)
);

// File: tb/hash_table_overflow_chaining_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the chained hash table. A predictor mirrors the
// slot memory, the chain links, the free scan pointer and both occupancy
// counters, and works out the one result that each accepted item causes.
// The checker compares every result, field by field, with the oldest
// expected result in the queue.
module hash_table_overflow_chaining_tb;
   import hto_pkg::*;

   localparam int MAIN_N  = 1024;
   localparam int OVF_N   = 256;
   localparam int TOTAL_N = MAIN_N + OVF_N;
   localparam longint CYCLE_LIMIT = 10000000;
   // Command code that the block does not know.
   localparam logic [CMD_W-1:0] CMD_BAD = 2'd3;

   logic clock;
   logic reset;
   hto_req_if req_chan ();
   hto_rsp_if rsp_chan ();

   hash_table_overflow_chaining i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   // Predicted table contents.
   logic [63:0]       tbl_key   [TOTAL_N];
   logic [31:0]       tbl_value [TOTAL_N];
   bit                tbl_used  [TOTAL_N];
   int unsigned       tbl_next  [TOTAL_N];
   bit                tbl_linked[TOTAL_N];
   int unsigned       tbl_prev  [TOTAL_N];
   int unsigned       free_ptr;
   int unsigned       main_cnt;
   int unsigned       ovf_cnt;

   rsp_item_type      expected_rsps[$];
   int                error_count = 0;
   longint            cycle_count = 0;
   bit                idle_enable = 1'b1;

   // Keys that were inserted recently, so lookups and duplicates hit.
   logic [63:0]       known_keys[$];
   logic [31:0]       known_hashes[$];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The run ends with a failure if it takes too long.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic rsp_item_type make_rsp(logic [2:0] st, int unsigned s,
                                             logic [31:0] v);
      rsp_item_type r;
      r.status        = st;
      r.result_slot   = s[SLOT_W-1:0];
      r.result_value  = v;
      r.main_used     = main_cnt[MAIN_USED_W-1:0];
      r.overflow_used = ovf_cnt[OVF_USED_W-1:0];
      return r;
   endfunction

   function automatic void clear_entry(int unsigned s);
      tbl_key[s]    = '0;
      tbl_value[s]  = '0;
      tbl_used[s]   = 1'b0;
      tbl_next[s]   = 0;
      tbl_linked[s] = 1'b0;
      tbl_prev[s]   = 0;
   endfunction

   function automatic void table_reset();
      for (int i = 0; i < TOTAL_N; i++) clear_entry(i);
      free_ptr = MAIN_N;
      main_cnt = 0;
      ovf_cnt  = 0;
   endfunction

   function automatic bit follows(int unsigned s);
      return tbl_linked[s] && tbl_next[s] < TOTAL_N;
   endfunction

   function automatic int unsigned last_in_chain(int unsigned head);
      int unsigned e;
      e = head;
      for (int n = 0; n < TOTAL_N && follows(e); n++) e = tbl_next[e];
      return e;
   endfunction

   // Returns the slot holding the key in the chain of main slot head, or -1.
   function automatic int search_chain(int unsigned head, logic [63:0] k);
      int unsigned e;
      e = head;
      if (!tbl_used[head]) return -1;
      for (int n = 0; n < TOTAL_N; n++) begin
         if (tbl_key[e] == k) return e;
         if (!follows(e)) break;
         e = tbl_next[e];
      end
      return -1;
   endfunction

   function automatic rsp_item_type predict_insert(int unsigned h, logic [63:0] k,
                                                   logic [31:0] v);
      int where;
      int unsigned tail, p;
      bit got;
      if (!tbl_used[h]) begin
         tbl_key[h] = k; tbl_value[h] = v; tbl_used[h] = 1'b1;
         tbl_linked[h] = 1'b0; tbl_next[h] = 0; tbl_prev[h] = 0;
         main_cnt++;
         return make_rsp(STATUS_INSERTED, h, v);
      end
      where = search_chain(h, k);
      if (where >= 0) return make_rsp(STATUS_PRESENT, where, tbl_value[where]);
      tail = last_in_chain(h);
      p = free_ptr;
      if (p < MAIN_N || p >= TOTAL_N) p = MAIN_N;
      if (tbl_used[p]) begin
         got = 1'b0;
         if (ovf_cnt >= OVF_N) return make_rsp(STATUS_FULL, 0, '0);
         for (int n = 1; n < OVF_N; n++) begin
            p++;
            if (p >= TOTAL_N) p = MAIN_N;
            if (!tbl_used[p]) begin
               got = 1'b1;
               break;
            end
         end
         if (!got) return make_rsp(STATUS_FULL, 0, '0);
      end
      tbl_next[tail] = p; tbl_linked[tail] = 1'b1;
      tbl_key[p] = k; tbl_value[p] = v; tbl_used[p] = 1'b1;
      tbl_linked[p] = 1'b0; tbl_next[p] = 0; tbl_prev[p] = tail;
      free_ptr = (p + 1 >= TOTAL_N) ? MAIN_N : p + 1;
      ovf_cnt++;
      return make_rsp(STATUS_INSERTED, p, v);
   endfunction

   function automatic rsp_item_type predict_remove(int unsigned s);
      int unsigned last, pv;
      if (s >= TOTAL_N) return make_rsp(STATUS_INVALID, 0, '0);
      if (!tbl_used[s]) return make_rsp(STATUS_NOT_FOUND, 0, '0);
      if (s < MAIN_N) begin
         if (follows(s)) begin
            // The chain's last entry moves up into the head slot.
            last = last_in_chain(s);
            pv = tbl_prev[last];
            if (pv < TOTAL_N) begin
               tbl_linked[pv] = 1'b0;
               tbl_next[pv] = 0;
            end
            tbl_key[s] = tbl_key[last];
            tbl_value[s] = tbl_value[last];
            clear_entry(last);
            if (ovf_cnt > 0) ovf_cnt--;
         end else begin
            clear_entry(s);
            if (main_cnt > 0) main_cnt--;
         end
      end else begin
         // Unlink an overflow entry from the middle or end of its chain.
         pv = tbl_prev[s];
         if (pv < TOTAL_N) begin
            tbl_linked[pv] = tbl_linked[s];
            tbl_next[pv] = tbl_next[s];
         end
         if (follows(s)) tbl_prev[tbl_next[s]] = pv;
         clear_entry(s);
         if (ovf_cnt > 0) ovf_cnt--;
      end
      return make_rsp(STATUS_REMOVED, s, '0);
   endfunction

   function automatic rsp_item_type predict_table(req_item_type it);
      int unsigned h;
      int where;
      h = it.hash % MAIN_N;
      case (it.cmd)
         CMD_INSERT: return predict_insert(h, it.key, it.value);
         CMD_LOOKUP: begin
            where = search_chain(h, it.key);
            if (where >= 0) return make_rsp(STATUS_FOUND, where, tbl_value[where]);
            return make_rsp(STATUS_NOT_FOUND, 0, '0);
         end
         CMD_REMOVE: return predict_remove(it.slot);
         default: return make_rsp(STATUS_INVALID, 0, '0);
      endcase
   endfunction

   task automatic idle_burst();
      repeat ($urandom_range(1, 17)) @(negedge clock);
   endtask

   // Drives one item from a falling edge and waits for its acceptance; the
   // expectation is queued at the accepting edge, before any result can come back.
   task automatic send_item(req_item_type it);
      @(negedge clock);
      if (idle_enable && $urandom_range(0, 5) == 0) idle_burst();
      req_chan.item  <= it;
      req_chan.valid <= 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_rsps.push_back(predict_table(it));
      if (it.cmd == CMD_INSERT && known_keys.size() < 400) begin
         known_keys.push_back(it.key);
         known_hashes.push_back(it.hash);
      end
      @(negedge clock);
      req_chan.valid <= 1'b0;
   endtask

   function automatic req_item_type make_item(logic [1:0] c, logic [31:0] h,
                                              logic [63:0] k, logic [31:0] v,
                                              logic [10:0] s);
      req_item_type it;
      it.cmd = c; it.hash = h; it.key = k; it.value = v; it.slot = s;
      return it;
   endfunction

   function automatic logic [63:0] rand_key();
      return {$urandom, $urandom};
   endfunction

   // Result side: random stalls, then compare against the oldest expectation.
   initial begin
      rsp_item_type want;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_enable && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready <= 1'b0;
            idle_burst();
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_rsps.size() == 0) begin
               $error("result with no item outstanding: status %0d",
                      rsp_chan.item.status);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_chan.item.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status,
                         rsp_chan.item.status);
                  error_count++;
               end
               if (rsp_chan.item.result_slot !== want.result_slot) begin
                  $error("result_slot: expected %0d, got %0d", want.result_slot,
                         rsp_chan.item.result_slot);
                  error_count++;
               end
               if (rsp_chan.item.result_value !== want.result_value) begin
                  $error("result_value: expected %0h, got %0h", want.result_value,
                         rsp_chan.item.result_value);
                  error_count++;
               end
               if (rsp_chan.item.main_used !== want.main_used) begin
                  $error("main_used: expected %0d, got %0d", want.main_used,
                         rsp_chan.item.main_used);
                  error_count++;
               end
               if (rsp_chan.item.overflow_used !== want.overflow_used) begin
                  $error("overflow_used: expected %0d, got %0d", want.overflow_used,
                         rsp_chan.item.overflow_used);
                  error_count++;
               end
            end
         end
      end
   end

   task automatic wait_drained();
      while (expected_rsps.size() != 0) @(negedge clock);
   endtask

   // Field extremes, every command, bad command and out-of-range slot,
   // key already stored, and collisions on the top main slot.
   task automatic test_directed();
      send_item(make_item(CMD_LOOKUP, 32'h0, 64'h0, 32'h0, 11'd0));
      send_item(make_item(CMD_REMOVE, 32'h0, 64'h0, 32'h0, 11'd0));
      send_item(make_item(CMD_INSERT, 32'h0, 64'h0, 32'h0, 11'd0));
      send_item(make_item(CMD_INSERT, 32'hFFFF_FFFF, '1, '1, '1));
      send_item(make_item(CMD_INSERT, 32'hFFFF_FFFF, 64'h5, 32'h1234, 11'd0));
      send_item(make_item(CMD_INSERT, 32'h0000_03FF, 64'h6, 32'h5678, 11'd0));
      send_item(make_item(CMD_INSERT, 32'hFFFF_FFFF, '1, 32'h0, 11'd0));
      send_item(make_item(CMD_LOOKUP, 32'hFFFF_FFFF, 64'h6, 32'h0, 11'd0));
      send_item(make_item(CMD_LOOKUP, 32'hFFFF_FFFF, 64'h7, 32'h0, 11'd0));
      send_item(make_item(CMD_LOOKUP, 32'h0, 64'h0, 32'h0, 11'd0));
      send_item(make_item(CMD_BAD, 32'h1, 64'h1, 32'h1, 11'd5));
      send_item(make_item(CMD_REMOVE, '1, '1, '1, 11'd1280));
      send_item(make_item(CMD_REMOVE, 32'h0, 64'h0, 32'h0, 11'h7FF));
      send_item(make_item(CMD_REMOVE, 32'h0, 64'h0, 32'h0, 11'd1279));
      send_item(make_item(CMD_REMOVE, 32'h0, 64'h0, 32'h0, 11'd1025));
      send_item(make_item(CMD_REMOVE, 32'h0, 64'h0, 32'h0, 11'd1023));
      send_item(make_item(CMD_LOOKUP, 32'h3FF, 64'h5, 32'h0, 11'd0));
      send_item(make_item(CMD_REMOVE, 32'h0, 64'h0, 32'h0, 11'd1023));
      send_item(make_item(CMD_REMOVE, 32'h0, 64'h0, 32'h0, 11'd1023));
      send_item(make_item(CMD_REMOVE, 32'h0, 64'h0, 32'h0, 11'd0));
      // Hold off until every result is back.
      wait_drained();
   endtask

   // Crowd main slot 7 until the overflow area fills and reports full,
   // then remove heads and middles to exercise relinking and wrap of the pointer.
   task automatic test_overflow_full();
      for (int i = 0; i < 270; i++)
         send_item(make_item(CMD_INSERT, {22'($urandom_range(0, 3)), 10'd7}, rand_key(),
                             $urandom, 11'd0));
      for (int i = 0; i < 60; i++)
         send_item(make_item(CMD_REMOVE, 32'h0, 64'h0, 32'h0,
                             ($urandom_range(0, 1) ? 11'd7 :
                              11'($urandom_range(MAIN_N, TOTAL_N - 1)))));
      for (int i = 0; i < 40; i++)
         send_item(make_item(CMD_INSERT, $urandom_range(0, 15), rand_key(),
                             $urandom, 11'd0));
      for (int i = 0; i < 280; i++)
         send_item(make_item(CMD_REMOVE, 32'h0, 64'h0, 32'h0,
                             11'($urandom_range(0, TOTAL_N - 1) < 100 ?
                                 $urandom_range(0, 15) :
                                 $urandom_range(MAIN_N, TOTAL_N - 1))));
   endtask

   // Mixed traffic on a narrow hash range so chains form, with known keys
   // looked up, reinserted and their slots removed.
   task automatic test_random_mix(int count);
      req_item_type it;
      int j;
      for (int i = 0; i < count; i++) begin
         it = make_item(CMD_INSERT, $urandom_range(0, 63) ^ ($urandom << 10), rand_key(),
                        $urandom, 11'($urandom_range(0, 2047)));
         case ($urandom_range(0, 9))
            0, 1, 2: it.cmd = CMD_INSERT;
            3: begin
               it.cmd = CMD_INSERT;
               if (known_keys.size() > 0) begin
                  j = $urandom_range(0, known_keys.size() - 1);
                  it.key = known_keys[j]; it.hash = known_hashes[j];
               end
            end
            4, 5: begin
               it.cmd = CMD_LOOKUP;
               if (known_keys.size() > 0) begin
                  j = $urandom_range(0, known_keys.size() - 1);
                  it.key = known_keys[j]; it.hash = known_hashes[j];
               end
            end
            6: it.cmd = CMD_LOOKUP;
            7: it.slot = 11'($urandom_range(0, 63));
            8: it.slot = 11'($urandom_range(MAIN_N, TOTAL_N - 1));
            default: it.cmd = ($urandom_range(0, 3) == 0) ? CMD_BAD : CMD_REMOVE;
         endcase
         if ($urandom_range(0, 9) >= 7 && it.cmd != CMD_BAD) it.cmd = CMD_REMOVE;
         send_item(it);
      end
   endtask

   initial begin
      table_reset();
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.item  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_overflow_full();
      test_random_mix(600);
      // The last stretch runs without any idling on either side.
      idle_enable = 1'b0;
      test_random_mix(300);

      wait_drained();
      repeat (100) @(negedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
